FILE: rtl/prs_pkg.sv
// Package for the power rail sequencer: codes, widths, reset values and shared types.
package prs_pkg;

  // Field widths
  localparam int SampleW    = 12;
  localparam int SampleBits = 12;
  localparam int RailW      = 3;
  localparam int StageW     = 4;
  localparam int TicksW     = 16;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;

  // Only the low SampleBits bits of a sample and of a threshold take part
  localparam logic [SampleW-1:0] SampleMask = SampleW'((1 << SampleBits) - 1);

  // Stage codes
  localparam logic [StageW-1:0] StageRampCore = 4'd0;
  localparam logic [StageW-1:0] StageWaitCore = 4'd1;
  localparam logic [StageW-1:0] StageRampFpga = 4'd2;
  localparam logic [StageW-1:0] StageWaitFpga = 4'd3;
  localparam logic [StageW-1:0] StageRampAvdd = 4'd4;
  localparam logic [StageW-1:0] StageWaitAvdd = 4'd5;
  localparam logic [StageW-1:0] StageRampDvdd = 4'd6;
  localparam logic [StageW-1:0] StageWaitDvdd = 4'd7;
  localparam logic [StageW-1:0] StageGood     = 4'd8;

  // Rail codes
  localparam logic [RailW-1:0] RailCore = 3'd0;
  localparam logic [RailW-1:0] RailSpi  = 3'd1;
  localparam logic [RailW-1:0] RailVpp  = 3'd2;
  localparam logic [RailW-1:0] RailAvdd = 3'd3;
  localparam logic [RailW-1:0] RailDvdd = 3'd4;

  // Op codes
  localparam logic OpTick   = 1'b0;
  localparam logic OpSample = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCoreThr = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSpiThr  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgVppThr  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAvddThr = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDvddThr = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRamp    = 3'd5;

  // Configuration reset values
  localparam logic [SampleW-1:0] CoreThrRst = 12'd1340;
  localparam logic [SampleW-1:0] SpiThrRst  = 12'd3685;
  localparam logic [SampleW-1:0] VppThrRst  = 12'd2790;
  localparam logic [SampleW-1:0] AvddThrRst = 12'd3685;
  localparam logic [SampleW-1:0] DvddThrRst = 12'd2015;
  localparam logic [TicksW-1:0]  RampRst    = 16'd10;

  typedef struct packed {
    logic [SampleW-1:0] core_thr;
    logic [SampleW-1:0] spi_thr;
    logic [SampleW-1:0] vpp_thr;
    logic [SampleW-1:0] avdd_thr;
    logic [SampleW-1:0] dvdd_thr;
    logic [TicksW-1:0]  ramp_ticks;
  } prs_cfg_t;

  typedef struct packed {
    logic [StageW-1:0] stage;
    logic [TicksW-1:0] ramp_count;
    logic              spi_good;
  } prs_state_t;

  typedef struct packed {
    logic              core_enable;
    logic              spi_enable;
    logic              vpp_enable;
    logic              avdd_enable;
    logic              dvdd_enable;
    logic              status_led;
    logic [StageW-1:0] stage;
    logic [RailW-1:0]  wanted_rail;
  } prs_result_t;

endpackage

FILE: rtl/power_rail_sequencer_core.sv
// Power rail sequencer: brings up five supply rails in order, one result word per input word.
//
// Input channel (in_valid_i / in_ready_o): each word is a time tick (op 0)
// or an ADC sample of one rail (op 1). Output channel (out_valid_o /
// out_ready_i): one word per input word carrying the regulator enables,
// the status LED, the stage code and the rail whose sample is awaited,
// all as they stand after that input word.
// The result is registered: a word accepted at a clock edge is loaded
// into the output register at that edge. Throughput is one word per
// cycle while the receiver keeps up; the stage update is a single pass
// of logic from the sequencer state registers to the output register.
// The output register decouples the sides: a new input word is taken
// whenever the output register is empty or is being read in the same
// cycle. While the receiver stalls with a result held, in_ready_o is low
// and the state does not move.
// Reset puts the sequencer in the core ramp stage with a cleared tick
// count and loads the default thresholds and ramp length. Configuration
// writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once and are
// meant for idle periods.
module power_rail_sequencer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [prs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [prs_pkg::CfgDataW-1:0]  cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [prs_pkg::RailW-1:0]     rail_i,
  input  logic [prs_pkg::SampleW-1:0]   sample_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          core_enable_o,
  output logic                          spi_enable_o,
  output logic                          vpp_enable_o,
  output logic                          avdd_enable_o,
  output logic                          dvdd_enable_o,
  output logic                          status_led_o,
  output logic [prs_pkg::StageW-1:0]    stage_o,
  output logic [prs_pkg::RailW-1:0]     wanted_rail_o
);
  import prs_pkg::*;

  prs_cfg_t    cfg_q;
  prs_state_t  state_q;
  prs_state_t  state_d;
  prs_result_t res_d;
  prs_result_t res_q;
  logic        out_valid_q;
  logic        in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.core_thr   <= CoreThrRst;
      cfg_q.spi_thr    <= SpiThrRst;
      cfg_q.vpp_thr    <= VppThrRst;
      cfg_q.avdd_thr   <= AvddThrRst;
      cfg_q.dvdd_thr   <= DvddThrRst;
      cfg_q.ramp_ticks <= RampRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCoreThr: cfg_q.core_thr   <= cfg_data_i[SampleW-1:0];
        CfgSpiThr:  cfg_q.spi_thr    <= cfg_data_i[SampleW-1:0];
        CfgVppThr:  cfg_q.vpp_thr    <= cfg_data_i[SampleW-1:0];
        CfgAvddThr: cfg_q.avdd_thr   <= cfg_data_i[SampleW-1:0];
        CfgDvddThr: cfg_q.dvdd_thr   <= cfg_data_i[SampleW-1:0];
        CfgRamp:    cfg_q.ramp_ticks <= cfg_data_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  prs_next u_next (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .op_i     (op_i),
    .rail_i   (rail_i),
    .sample_i (sample_i),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.stage      <= StageRampCore;
      state_q.ramp_count <= '0;
      state_q.spi_good   <= 1'b0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign core_enable_o = res_q.core_enable;
  assign spi_enable_o  = res_q.spi_enable;
  assign vpp_enable_o  = res_q.vpp_enable;
  assign avdd_enable_o = res_q.avdd_enable;
  assign dvdd_enable_o = res_q.dvdd_enable;
  assign status_led_o  = res_q.status_led;
  assign stage_o       = res_q.stage;
  assign wanted_rail_o = res_q.wanted_rail;

endmodule

FILE: rtl/prs_next.sv
// Next-state and result logic of the power rail sequencer for one input word.
module prs_next (
  input  prs_pkg::prs_cfg_t               cfg_i,
  input  prs_pkg::prs_state_t             state_i,
  input  logic                            op_i,
  input  logic [prs_pkg::RailW-1:0]       rail_i,
  input  logic [prs_pkg::SampleW-1:0]     sample_i,
  output prs_pkg::prs_state_t             state_o,
  output prs_pkg::prs_result_t            result_o
);
  import prs_pkg::*;

  logic [StageW-1:0]  stage_cur;
  logic [TicksW:0]    count_inc;
  logic [SampleW-1:0] smp;
  logic [SampleW-1:0] wait_thr;
  logic [RailW-1:0]   wait_rail;
  logic               above_spi;
  logic               above_vpp;
  logic               above_wait;

  // Clamp unreachable stage codes to all-good
  assign stage_cur = (state_i.stage > StageGood) ? StageGood : state_i.stage;
  assign count_inc = {1'b0, state_i.ramp_count} + 1'b1;
  assign smp       = sample_i & SampleMask;

  // Threshold and rail for the single-rail wait stages
  always_comb begin
    case (stage_cur)
      StageWaitCore: begin
        wait_thr  = cfg_i.core_thr;
        wait_rail = RailCore;
      end
      StageWaitAvdd: begin
        wait_thr  = cfg_i.avdd_thr;
        wait_rail = RailAvdd;
      end
      StageWaitDvdd: begin
        wait_thr  = cfg_i.dvdd_thr;
        wait_rail = RailDvdd;
      end
      default: begin
        wait_thr  = cfg_i.vpp_thr;
        wait_rail = RailCore;
      end
    endcase
  end

  assign above_spi  = smp > (cfg_i.spi_thr & SampleMask);
  assign above_vpp  = smp > (cfg_i.vpp_thr & SampleMask);
  assign above_wait = smp > (wait_thr & SampleMask);

  // Stage transitions
  always_comb begin
    state_o       = state_i;
    state_o.stage = stage_cur;
    if (stage_cur < StageGood) begin
      if (!stage_cur[0]) begin
        // ramp stage: count ticks
        if (op_i == OpTick) begin
          if (count_inc >= {1'b0, cfg_i.ramp_ticks}) begin
            state_o.ramp_count = '0;
            state_o.stage      = stage_cur + 1'b1;
          end else begin
            state_o.ramp_count = count_inc[TicksW-1:0];
          end
        end
      end else if (op_i == OpSample) begin
        if (stage_cur == StageWaitFpga) begin
          if (rail_i == RailSpi) begin
            state_o.spi_good = above_spi;
          end else if (rail_i == RailVpp && state_i.spi_good && above_vpp) begin
            state_o.spi_good = 1'b0;
            state_o.stage    = StageRampAvdd;
          end
        end else if (rail_i == wait_rail && above_wait) begin
          state_o.ramp_count = '0;
          state_o.stage      = stage_cur + 1'b1;
        end
      end
    end
  end

  // Result fields from the updated state
  always_comb begin
    result_o.core_enable = 1'b1;
    result_o.spi_enable  = state_o.stage >= StageRampFpga;
    result_o.vpp_enable  = state_o.stage >= StageRampFpga;
    result_o.avdd_enable = state_o.stage >= StageRampAvdd;
    result_o.dvdd_enable = state_o.stage >= StageRampDvdd;
    result_o.status_led  = state_o.stage >= StageGood;
    result_o.stage       = state_o.stage;
    case (state_o.stage)
      StageRampCore, StageWaitCore: result_o.wanted_rail = RailCore;
      StageRampFpga, StageWaitFpga:
        result_o.wanted_rail = state_o.spi_good ? RailVpp : RailSpi;
      StageRampAvdd, StageWaitAvdd: result_o.wanted_rail = RailAvdd;
      StageRampDvdd, StageWaitDvdd: result_o.wanted_rail = RailDvdd;
      default:                      result_o.wanted_rail = RailCore;
    endcase
  end

endmodule

FILE: bench/rail_check_pkg.sv
// Rail sequencer bench scoreboard: predicts each status word and checks what the block returns.
`timescale 1ns / 1ps
package rail_check_pkg;
  import prs_pkg::*;

  // One input word as the bench drives it
  typedef struct packed {
    logic               op;
    logic [RailW-1:0]   rail;
    logic [SampleW-1:0] sample;
  } rail_word_t;

  class rail_scoreboard;
    prs_cfg_t    cfg;
    prs_state_t  seq;
    prs_result_t status_due[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned writes;

    function new();
      cfg = '{core_thr: CoreThrRst, spi_thr: SpiThrRst, vpp_thr: VppThrRst,
              avdd_thr: AvddThrRst, dvdd_thr: DvddThrRst, ramp_ticks: RampRst};
      seq = '{stage: StageRampCore, ramp_count: '0, spi_good: 1'b0};
      mismatches = 0;
      checked = 0;
      writes = 0;
    endfunction

    // Mirror of a register write; thresholds keep the low sample bits
    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      writes++;
      case (idx)
        CfgCoreThr: cfg.core_thr   = data[SampleW-1:0];
        CfgSpiThr:  cfg.spi_thr    = data[SampleW-1:0];
        CfgVppThr:  cfg.vpp_thr    = data[SampleW-1:0];
        CfgAvddThr: cfg.avdd_thr   = data[SampleW-1:0];
        CfgDvddThr: cfg.dvdd_thr   = data[SampleW-1:0];
        CfgRamp:    cfg.ramp_ticks = data[TicksW-1:0];
        default: ;
      endcase
    endfunction

    // Rail a stage belongs to; the SPI/VPP group points at VPP once SPI is good
    function logic [RailW-1:0] rail_of(logic [StageW-1:0] stg, logic good);
      case (stg)
        StageRampCore, StageWaitCore: return RailCore;
        StageRampFpga, StageWaitFpga: return good ? RailVpp : RailSpi;
        StageRampAvdd, StageWaitAvdd: return RailAvdd;
        StageRampDvdd, StageWaitDvdd: return RailDvdd;
        default: return RailCore;
      endcase
    endfunction

    // Threshold a sample of this rail must exceed
    function logic [SampleW-1:0] level_of(logic [RailW-1:0] r);
      case (r)
        RailCore: return cfg.core_thr;
        RailSpi:  return cfg.spi_thr;
        RailVpp:  return cfg.vpp_thr;
        RailAvdd: return cfg.avdd_thr;
        RailDvdd: return cfg.dvdd_thr;
        default:  return SampleMask;
      endcase
    endfunction

    function logic [RailW-1:0] awaited_rail();
      return rail_of(seq.stage, seq.spi_good);
    endfunction

    // One step of the sequencer on state s; returns the status word after it
    function prs_result_t advance_sequence(rail_word_t w, inout prs_state_t s);
      prs_result_t r;
      logic [StageW-1:0] stg;
      logic [SampleW-1:0] smp;
      logic [RailW-1:0] grp;
      smp = w.sample & SampleMask;
      stg = (s.stage > StageGood) ? StageGood : s.stage;
      if (stg < StageGood) begin
        if (!stg[0]) begin
          // ramp: count ticks up to the configured length
          if (w.op == OpTick) begin
            if (32'(s.ramp_count) + 32'd1 >= 32'(cfg.ramp_ticks)) begin
              s.ramp_count = '0;
              stg = stg + 1'b1;
            end else begin
              s.ramp_count = s.ramp_count + 1'b1;
            end
          end
        end else if (w.op == OpSample) begin
          if (stg == StageWaitFpga) begin
            // SPI sample refreshes the flag; VPP only counts while it holds
            if (w.rail == RailSpi) begin
              s.spi_good = smp > (cfg.spi_thr & SampleMask);
            end else if (w.rail == RailVpp && s.spi_good &&
                         smp > (cfg.vpp_thr & SampleMask)) begin
              s.spi_good = 1'b0;
              stg = StageRampAvdd;
            end
          end else begin
            grp = rail_of(stg, s.spi_good);
            if (w.rail == grp && smp > (level_of(grp) & SampleMask)) begin
              s.ramp_count = '0;
              stg = stg + 1'b1;
            end
          end
        end
      end
      s.stage = stg;
      r.core_enable = 1'b1;
      r.spi_enable  = (stg >= StageRampFpga);
      r.vpp_enable  = (stg >= StageRampFpga);
      r.avdd_enable = (stg >= StageRampAvdd);
      r.dvdd_enable = (stg >= StageRampDvdd);
      r.status_led  = (stg >= StageGood);
      r.stage       = stg;
      r.wanted_rail = rail_of(stg, s.spi_good);
      return r;
    endfunction

    // Status word a word would give, state left untouched
    function prs_result_t peek(rail_word_t w);
      prs_state_t s;
      s = seq;
      return advance_sequence(w, s);
    endfunction

    function void note_word(rail_word_t w);
      status_due.push_back(advance_sequence(w, seq));
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task match_field(string name, logic [3:0] got, logic [3:0] want);
      if (got !== want)
        report($sformatf("status word %0d %s: got %0h, want %0h", checked, name, got, want));
    endtask

    task check_status(prs_result_t got);
      prs_result_t want;
      checked++;
      if (status_due.size() == 0) begin
        report($sformatf("status word %0d came with none pending", checked));
        return;
      end
      want = status_due.pop_front();
      match_field("core_enable", got.core_enable, want.core_enable);
      match_field("spi_enable", got.spi_enable, want.spi_enable);
      match_field("vpp_enable", got.vpp_enable, want.vpp_enable);
      match_field("avdd_enable", got.avdd_enable, want.avdd_enable);
      match_field("dvdd_enable", got.dvdd_enable, want.dvdd_enable);
      match_field("status_led", got.status_led, want.status_led);
      match_field("stage", got.stage, want.stage);
      match_field("wanted_rail", got.wanted_rail, want.wanted_rail);
    endtask
  endclass

endpackage

FILE: bench/tb.sv
// Top-level bench for the power rail sequencer: drives ticks and rail samples, checks status words.
`timescale 1ns / 1ps
module tb;
  import prs_pkg::*;
  import rail_check_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  // rail codes the block has no rail for
  localparam logic [RailW-1:0] RailSpare5 = 3'd5;
  localparam logic [RailW-1:0] RailSpare6 = 3'd6;
  localparam logic [RailW-1:0] RailSpare7 = 3'd7;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic                op        = OpTick;
  logic [RailW-1:0]    rail      = '0;
  logic [SampleW-1:0]  sample    = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                core_en, spi_en, vpp_en, avdd_en, dvdd_en, led;
  logic [StageW-1:0]   stage;
  logic [RailW-1:0]    wanted;
  prs_result_t         seen;

  rail_scoreboard sb;
  bit          calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;
  int unsigned words_sent = 0;

  power_rail_sequencer_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .op_i          (op),
    .rail_i        (rail),
    .sample_i      (sample),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .core_enable_o (core_en),
    .spi_enable_o  (spi_en),
    .vpp_enable_o  (vpp_en),
    .avdd_enable_o (avdd_en),
    .dvdd_enable_o (dvdd_en),
    .status_led_o  (led),
    .stage_o       (stage),
    .wanted_rail_o (wanted)
  );

  assign seen = {core_en, spi_en, vpp_en, avdd_en, dvdd_en, led, stage, wanted};

  // 125 MHz clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: stopped after %0d cycles, %0d status words outstanding",
               cycles, sb.status_due.size());
      $display("FAIL");
      $finish;
    end
  end

  // Idle lengths: mostly none or short, a few long; none during calm stretches
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Status word receiver with random stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_status(seen);
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  function automatic rail_word_t word(logic o, logic [RailW-1:0] r, logic [SampleW-1:0] s);
    rail_word_t w;
    w.op = o;
    w.rail = r;
    w.sample = s;
    return w;
  endfunction

  // Sample values around a threshold, plus the extremes
  function automatic logic [SampleW-1:0] near_level(logic [SampleW-1:0] lvl);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return SampleMask;
      2: return lvl;
      3: return (lvl == SampleMask) ? lvl : lvl + 1'b1;
      default: return SampleW'($urandom);
    endcase
  endfunction

  // Random word that leaves the sequencer in its current stage
  function automatic rail_word_t noise_word();
    rail_word_t w;
    logic [StageW-1:0] stg;
    stg = sb.seq.stage;
    w.op = ($urandom_range(0, 99) < (stg[0] ? 15 : 70)) ? OpTick : OpSample;
    if ($urandom_range(0, 9) < 6) begin
      w.rail = sb.awaited_rail();
      if (stg == StageWaitFpga && $urandom_range(0, 1) == 1)
        w.rail = (w.rail == RailSpi) ? RailVpp : RailSpi;
    end else begin
      w.rail = RailW'($urandom);
    end
    w.sample = near_level(sb.level_of(w.rail));
    if (sb.peek(w).stage != stg) begin
      if (w.op == OpTick) w.op = OpSample;
      else w.sample = SampleW'($urandom_range(0, int'(sb.level_of(w.rail))));
    end
    return w;
  endfunction

  // Word that moves the current stage toward the next one
  function automatic rail_word_t push_word();
    rail_word_t w;
    w.rail = RailW'($urandom);
    w.sample = SampleW'($urandom);
    if (!sb.seq.stage[0]) begin
      w.op = OpTick;
    end else begin
      w.op = OpSample;
      w.rail = sb.awaited_rail();
      w.sample = SampleW'($urandom_range(int'(sb.level_of(w.rail)) + 1, int'(SampleMask)));
    end
    return w;
  endfunction

  // Threshold choice: a hold phase may block the stage, a release phase never does
  function automatic logic [SampleW-1:0] pick_level(bit hold);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (hold) begin
      if (roll < 20) return SampleMask;
      if (roll < 35) return '0;
      return SampleW'($urandom);
    end
    if (roll < 25) return '0;
    return SampleW'($urandom_range(0, int'(SampleMask) - 1));
  endfunction

  // Threshold write data, upper bits random
  function automatic logic [CfgDataW-1:0] level_data(logic [SampleW-1:0] lvl);
    return {(CfgDataW-SampleW)'($urandom), lvl};
  endfunction

  task automatic poke_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic send_word(input rail_word_t w);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= w.op;
    rail     <= w.rail;
    sample   <= w.sample;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
    words_sent++;
  endtask

  // Drain: no input, every status word back, then a short tail
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.status_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Registers for the stage: hold may keep it in place, release lets it finish
  task automatic set_hurdle(input logic [StageW-1:0] stg, input bit hold);
    logic [TicksW-1:0] ticks;
    case (stg)
      StageWaitCore: poke_reg(CfgCoreThr, level_data(hold ? SampleMask : '0));
      StageWaitFpga: begin
        poke_reg(CfgSpiThr, level_data(pick_level(hold)));
        poke_reg(CfgVppThr, level_data(pick_level(hold)));
      end
      StageWaitAvdd: poke_reg(CfgAvddThr, level_data(pick_level(hold)));
      StageWaitDvdd: poke_reg(CfgDvddThr, level_data(pick_level(hold)));
      StageRampFpga: poke_reg(CfgRamp, hold ? '1 : '0);
      default: begin
        // later ramps: long while holding, then up to just past the count so far
        if (hold) ticks = TicksW'($urandom_range(200, 1000));
        else ticks = TicksW'($urandom_range(0, sb.seq.ramp_count + 3));
        poke_reg(CfgRamp, ticks);
      end
    endcase
  endtask

  // One stage: random words that keep it in place, then pushes until it moves on
  task automatic run_stage(input int unsigned budget);
    logic [StageW-1:0] stg;
    stg = sb.seq.stage;
    settle();
    calm = ($urandom_range(0, 3) == 0);
    set_hurdle(stg, 1'b1);
    repeat (budget) send_word(noise_word());
    settle();
    set_hurdle(stg, 1'b0);
    while (sb.seq.stage == stg)
      send_word(($urandom_range(0, 1) == 1) ? push_word() : noise_word());
  endtask

  initial begin : stimulus
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: samples ignored while ramping, ramp of ten ticks
    send_word(word(OpSample, RailCore, SampleMask));
    send_word(word(OpSample, RailSpare7, '0));
    send_word(word(OpSample, RailDvdd, SampleMask));
    repeat (9) send_word(word(OpTick, RailCore, '0));
    send_word(word(OpSample, RailCore, SampleMask));
    send_word(word(OpTick, RailSpare7, SampleMask));
    // core wait: ticks, other rails and a sample equal to the threshold do nothing
    send_word(word(OpTick, RailCore, '0));
    send_word(word(OpSample, RailSpi, SampleMask));
    send_word(word(OpSample, RailSpare5, SampleMask));
    send_word(word(OpSample, RailSpare6, SampleMask));
    send_word(word(OpSample, RailCore, CoreThrRst));
    send_word(word(OpSample, RailCore, '0));

    // Random part, stage by stage up to all good
    while (sb.seq.stage < StageGood) run_stage($urandom_range(60, 100));

    // All good: fresh settings and random words change nothing
    settle();
    calm = 1'b0;
    poke_reg(CfgCoreThr, CfgDataW'($urandom));
    poke_reg(CfgSpiThr, CfgDataW'($urandom));
    poke_reg(CfgVppThr, CfgDataW'($urandom));
    poke_reg(CfgAvddThr, CfgDataW'($urandom));
    poke_reg(CfgDvddThr, CfgDataW'($urandom));
    poke_reg(CfgRamp, CfgDataW'($urandom));
    repeat (40) send_word(noise_word());

    settle();
    repeat (8) @(posedge clk);
    $display("tb: %0d words sent, %0d status words checked, %0d register writes",
             words_sent, sb.checked, sb.writes);
    $display("tb: sequence ran from core ramp to stage %0d with %0d mismatches",
             sb.seq.stage, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
